FILE: hdl/cre_pkg.sv
// ----------------------------------------------------------------------------
// cre_pkg
// Shared types, character codes and class lookup for the character range
// expander.
// ----------------------------------------------------------------------------
package cre_pkg;

    // Character codes
    localparam logic [7:0] CHR_UPPER_A = 8'h41;
    localparam logic [7:0] CHR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHR_LOWER_A = 8'h61;
    localparam logic [7:0] CHR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CHR_DIGIT_0 = 8'h30;
    localparam logic [7:0] CHR_DIGIT_9 = 8'h39;
    localparam logic [7:0] CHR_HYPHEN  = 8'h2D;

    // Character classes
    typedef enum logic [1:0] {
        CLS_NONE  = 2'd0,
        CLS_UPPER = 2'd1,
        CLS_LOWER = 2'd2,
        CLS_DIGIT = 2'd3
    } char_class_t;

    // Input beat
    typedef struct packed {
        logic [7:0] char_in;
        logic       is_final;
    } in_item_t;

    // Result beat
    typedef struct packed {
        logic [7:0] char_out;
        logic       has_char;
        logic       run_last;
        logic       text_end;
    } out_item_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic emit;
    } cre_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic work_left;
        logic slot_free;
    } cre_status_t;

    function automatic char_class_t char_class(input logic [7:0] c);
        char_class_t cls;
        cls = CLS_NONE;
        if (c >= CHR_UPPER_A && c <= CHR_UPPER_Z) begin
            cls = CLS_UPPER;
        end else if (c >= CHR_LOWER_A && c <= CHR_LOWER_Z) begin
            cls = CLS_LOWER;
        end else if (c >= CHR_DIGIT_0 && c <= CHR_DIGIT_9) begin
            cls = CLS_DIGIT;
        end
        return cls;
    endfunction

endpackage

FILE: hdl/cre_ctrl.sv
// ----------------------------------------------------------------------------
// cre_ctrl
// Controller: takes one input beat at a time, then steps the datapath
// through its results until no work is left.
// ----------------------------------------------------------------------------
module cre_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  cre_pkg::cre_status_t status,
    output cre_pkg::cre_cmd_t    cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t state_reg;
    logic   ready_reg;

    // Decode commands
    always_comb begin
        cmd.load = ready_reg && s_valid;
        cmd.emit = (state_reg == ST_RUN) && status.work_left && status.slot_free;
    end

    assign s_ready = ready_reg;

    // Hold state and ready
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b1;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        state_reg <= ST_RUN;
                        ready_reg <= 1'b0;
                    end
                end
                ST_RUN: begin
                    if (!status.work_left) begin
                        state_reg <= ST_IDLE;
                        ready_reg <= 1'b1;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                    ready_reg <= 1'b1;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_ready_matches_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        ready_reg == (state_reg == ST_IDLE))
        else $error("ready out of step with controller state");
`endif

endmodule

FILE: hdl/cre_datapath.sv
// ----------------------------------------------------------------------------
// cre_datapath
// Datapath: text state, per-item work plan, range counter and output
// register.
// ----------------------------------------------------------------------------
module cre_datapath (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cre_pkg::in_item_t    s_data,
    input  cre_pkg::cre_cmd_t    cmd,
    output cre_pkg::cre_status_t status,
    output logic                 m_valid,
    input  logic                 m_ready,
    output cre_pkg::out_item_t   m_data
);

    // Text state
    logic [7:0] prev_reg, prev_next;
    logic       pending_reg, pending_next;

    // Work plan for the current item
    logic [7:0] cur_reg, cur_next;
    logic [7:0] end_reg, end_next;
    logic       range_reg, range_next;
    logic [1:0] hyp_reg, hyp_next;
    logic       char_en_reg, char_en_next;
    logic       mark_reg, mark_next;
    logic [7:0] char_reg, char_next;
    logic       final_reg, final_next;

    // Output register
    logic                m_valid_reg, m_valid_next;
    cre_pkg::out_item_t  m_data_reg, m_data_next;

    // Load-time decode
    logic                 is_hyp;
    cre_pkg::char_class_t cls_prev, cls_c;
    logic                 range_ok, range_fill;
    logic [1:0]           hyp_load;
    logic                 char_load;

    always_comb begin
        is_hyp     = (s_data.char_in == cre_pkg::CHR_HYPHEN);
        cls_prev   = cre_pkg::char_class(prev_reg);
        cls_c      = cre_pkg::char_class(s_data.char_in);
        range_ok   = pending_reg && !is_hyp && (cls_prev != cre_pkg::CLS_NONE) &&
                     (cls_prev == cls_c) && (prev_reg < s_data.char_in);
        range_fill = range_ok && (s_data.char_in != prev_reg + 8'd1);
        hyp_load   = {1'b0, pending_reg && !range_ok} + {1'b0, is_hyp && s_data.is_final};
        char_load  = !is_hyp && (cls_c != cre_pkg::CLS_NONE);
    end

    assign status.work_left = range_reg || (hyp_reg != 2'd0) || char_en_reg || mark_reg;
    assign status.slot_free = !m_valid_reg || m_ready;

    // Plan, advance and emit
    always_comb begin
        prev_next    = prev_reg;
        pending_next = pending_reg;
        cur_next     = cur_reg;
        end_next     = end_reg;
        range_next   = range_reg;
        hyp_next     = hyp_reg;
        char_en_next = char_en_reg;
        mark_next    = mark_reg;
        char_next    = char_reg;
        final_next   = final_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        if (cmd.load) begin
            cur_next     = prev_reg + 8'd1;
            end_next     = s_data.char_in;
            range_next   = range_fill;
            hyp_next     = hyp_load;
            char_en_next = char_load;
            mark_next    = s_data.is_final && !range_fill && (hyp_load == 2'd0) && !char_load;
            char_next    = s_data.char_in;
            final_next   = s_data.is_final;
            if (is_hyp) begin
                if (pending_reg) begin
                    prev_next = s_data.char_in;
                end
                pending_next = 1'b1;
            end else begin
                prev_next    = s_data.char_in;
                pending_next = 1'b0;
            end
            if (s_data.is_final) begin
                prev_next    = 8'd0;
                pending_next = 1'b0;
            end
        end else if (cmd.emit) begin
            m_valid_next         = 1'b1;
            m_data_next.has_char = 1'b1;
            m_data_next.text_end = final_reg;
            if (range_reg) begin
                m_data_next.char_out = cur_reg;
                cur_next             = cur_reg + 8'd1;
                range_next           = (cur_reg + 8'd1 != end_reg);
            end else if (hyp_reg != 2'd0) begin
                m_data_next.char_out = cre_pkg::CHR_HYPHEN;
                hyp_next             = hyp_reg - 2'd1;
            end else if (char_en_reg) begin
                m_data_next.char_out = char_reg;
                char_en_next         = 1'b0;
            end else begin
                m_data_next.char_out = 8'd0;
                m_data_next.has_char = 1'b0;
                mark_next            = 1'b0;
            end
            m_data_next.run_last = !range_next && (hyp_next == 2'd0) &&
                                   !char_en_next && !mark_next;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg    <= 8'd0;
            pending_reg <= 1'b0;
            range_reg   <= 1'b0;
            hyp_reg     <= 2'd0;
            char_en_reg <= 1'b0;
            mark_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            prev_reg    <= prev_next;
            pending_reg <= pending_next;
            range_reg   <= range_next;
            hyp_reg     <= hyp_next;
            char_en_reg <= char_en_next;
            mark_reg    <= mark_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        cur_reg    <= cur_next;
        end_reg    <= end_next;
        char_reg   <= char_next;
        final_reg  <= final_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    a_load_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |-> !status.work_left)
        else $error("item loaded while earlier work remains");

    a_emit_has_work: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> status.work_left && status.slot_free)
        else $error("emit without work or free output slot");

    a_marker_is_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_data_reg.has_char |-> m_data_reg.run_last && m_data_reg.text_end)
        else $error("empty marker outside end of text");

    a_final_clears_state: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load && s_data.is_final |=> prev_reg == 8'd0 && !pending_reg)
        else $error("text state not cleared after final beat");
`endif

endmodule

FILE: hdl/character_range_expander.sv
// ----------------------------------------------------------------------------
// character_range_expander
// Expands range shorthand (a-e, 2-5) in a byte stream; keeps letters,
// digits and hyphens that form no range, drops other bytes.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_data carry one text byte per beat, with is_final on
//   the last byte of a text. m_valid/m_ready/m_data carry result beats:
//   run_last marks the last result of an input beat, text_end marks every
//   result of the final input beat, has_char 0 is an empty end marker.
//   An input beat yields 0 to 25 results. One beat is worked at a time:
//   accepting it loads the work plan, then the block emits one result per
//   cycle into its output register while the slot is free, returns to ready
//   when no work is left; under a slow receiver the last result can still
//   wait in the output register while the next item is accepted.
//   When m_ready is low the emit sequence holds on the waiting result.
//   After reset no hyphen is pending and there is no left neighbor; the
//   same holds after each final beat, so the next beat starts a new text.
// ----------------------------------------------------------------------------
module character_range_expander (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  cre_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output cre_pkg::out_item_t m_data
);

    cre_pkg::cre_cmd_t    cmd;
    cre_pkg::cre_status_t status;

    cre_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    cre_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .status  (status),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives byte texts into the character range expander and checks every
// result beat against an in-bench model of the hyphen range expansion or
// a table beat. A short table of hand-picked texts runs first, then random
// texts, mostly ranges, letters, digits and hyphens, under varying idle rates
// on both channels, one long receiver stall and one sender drain pause.
// ----------------------------------------------------------------------------
module testbench;

    localparam int                 LONG_STALL   = 300;
    localparam int                 DRAIN_CYCLES = 40;
    localparam int                 PHASE_ITEMS  = 40;
    localparam cre_pkg::out_item_t NO_RESULT    = '0;

    // One row of the directed text table
    typedef struct {
        logic [7:0]         ch;
        logic               fin;
        bit                 use_want;
        cre_pkg::out_item_t want;
    } text_row_t;

    logic               aclk    = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    cre_pkg::in_item_t  s_data  = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    cre_pkg::out_item_t m_data;

    // Expected result beats, oldest first, and the beats of the latest byte
    cre_pkg::out_item_t expanded_chars[$];
    cre_pkg::out_item_t step_chars[$];

    // Model state: left neighbor byte and held hyphen
    logic [7:0] left_byte   = 8'h00;
    logic       hyphen_held = 1'b0;

    int error_count       = 0;
    int sender_idle_pct   = 24;
    int receiver_idle_pct = 63;
    int stall_asked       = 0;
    int stall_served      = 0;
    int stall_left        = 0;

    text_row_t directed_rows [25] = '{
        '{cre_pkg::CHR_HYPHEN, 1'b1, 1'b1, '{cre_pkg::CHR_HYPHEN, 1'b1, 1'b1, 1'b1}},
        '{8'h00,               1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1}},
        '{8'hFF,               1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1}},
        '{"A",                 1'b0, 1'b1, '{"A", 1'b1, 1'b1, 1'b0}},
        '{cre_pkg::CHR_HYPHEN, 1'b0, 1'b0, NO_RESULT},
        '{"Z",                 1'b0, 1'b0, NO_RESULT},
        '{"a",                 1'b0, 1'b1, '{"a", 1'b1, 1'b1, 1'b0}},
        '{cre_pkg::CHR_HYPHEN, 1'b0, 1'b0, NO_RESULT},
        '{"z",                 1'b0, 1'b0, NO_RESULT},
        '{"0",                 1'b0, 1'b1, '{"0", 1'b1, 1'b1, 1'b0}},
        '{cre_pkg::CHR_HYPHEN, 1'b0, 1'b0, NO_RESULT},
        '{"9",                 1'b0, 1'b0, NO_RESULT},
        '{cre_pkg::CHR_HYPHEN, 1'b0, 1'b0, NO_RESULT},
        '{cre_pkg::CHR_HYPHEN, 1'b0, 1'b0, NO_RESULT},
        '{"5",                 1'b0, 1'b0, NO_RESULT},
        '{cre_pkg::CHR_HYPHEN, 1'b0, 1'b0, NO_RESULT},
        '{"b",                 1'b0, 1'b0, NO_RESULT},
        '{cre_pkg::CHR_HYPHEN, 1'b0, 1'b0, NO_RESULT},
        '{"c",                 1'b0, 1'b0, NO_RESULT},
        '{cre_pkg::CHR_HYPHEN, 1'b0, 1'b0, NO_RESULT},
        '{"a",                 1'b0, 1'b0, NO_RESULT},
        '{8'h00,               1'b0, 1'b0, NO_RESULT},
        '{cre_pkg::CHR_HYPHEN, 1'b0, 1'b0, NO_RESULT},
        '{"x",                 1'b0, 1'b0, NO_RESULT},
        '{cre_pkg::CHR_HYPHEN, 1'b1, 1'b1, '{cre_pkg::CHR_HYPHEN, 1'b1, 1'b1, 1'b1}}
    };

    character_range_expander dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Toggle the clock every half period
    always #6 aclk = ~aclk;

    // Classify a byte as upper case, lower case, digit or none
    function automatic cre_pkg::char_class_t byte_class(input logic [7:0] c);
        if (c >= "A" && c <= "Z") return cre_pkg::CLS_UPPER;
        if (c >= "a" && c <= "z") return cre_pkg::CLS_LOWER;
        if (c >= "0" && c <= "9") return cre_pkg::CLS_DIGIT;
        return cre_pkg::CLS_NONE;
    endfunction

    function automatic void push_char(input logic [7:0] c, input logic has);
        step_chars.push_back('{c, has, 1'b0, 1'b0});
    endfunction

    // Replace a held hyphen by the span between its neighbors, or keep it
    function automatic void resolve_span(input logic [7:0] lhs, input logic [7:0] rhs);
        logic [7:0] c;
        if (byte_class(lhs) != cre_pkg::CLS_NONE && byte_class(lhs) == byte_class(rhs)
                && lhs < rhs) begin
            for (c = lhs + 8'd1; c < rhs; c++) push_char(c, 1'b1);
        end else begin
            push_char(cre_pkg::CHR_HYPHEN, 1'b1);
        end
    endfunction

    // Work out the result beats of one accepted text byte
    function automatic void expand_byte(input logic [7:0] ch, input logic fin);
        step_chars.delete();
        if (ch == cre_pkg::CHR_HYPHEN) begin
            if (hyphen_held) begin
                resolve_span(left_byte, ch);
                left_byte = ch;
            end
            hyphen_held = 1'b1;
            // no right neighbor at the end of text
            if (fin) begin
                push_char(cre_pkg::CHR_HYPHEN, 1'b1);
                hyphen_held = 1'b0;
            end
        end else begin
            if (hyphen_held) begin
                resolve_span(left_byte, ch);
                hyphen_held = 1'b0;
            end
            if (byte_class(ch) != cre_pkg::CLS_NONE) push_char(ch, 1'b1);
            left_byte = ch;
        end
        if (fin) begin
            if (step_chars.size() == 0) push_char(8'h00, 1'b0);
            foreach (step_chars[i]) step_chars[i].text_end = 1'b1;
            left_byte   = 8'h00;
            hyphen_held = 1'b0;
        end
        if (step_chars.size() != 0) step_chars[step_chars.size() - 1].run_last = 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH at %0t: %s: got %0h, expected %0h", $realtime, what, got, want);
        error_count++;
    endtask

    // Offer one byte, wait for its beat, then record what it should produce
    task automatic offer_item(input logic [7:0] ch, input logic fin, input bit use_want,
                              input cre_pkg::out_item_t want);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < sender_idle_pct) gap++;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{char_in: ch, is_final: fin};
        do @(posedge aclk); while (!s_ready);
        expand_byte(ch, fin);
        if (use_want) begin
            expanded_chars.push_back(want);
        end else begin
            foreach (step_chars[i]) expanded_chars.push_back(step_chars[i]);
        end
    endtask

    // Pick a random byte of the given class
    function automatic logic [7:0] class_byte(input int cls);
        case (cls)
            cre_pkg::CLS_UPPER: return 8'($urandom_range("A", "Z"));
            cre_pkg::CLS_LOWER: return 8'($urandom_range("a", "z"));
            default:            return 8'($urandom_range("0", "9"));
        endcase
    endfunction

    // Build one text, mostly ranges and letters with some noise, and send it
    task automatic send_random_text(inout int counted);
        logic [7:0] text_bytes[$];
        logic [7:0] lo;
        logic [7:0] hi;
        logic [7:0] swap;
        int         pieces;
        int         pick;
        int         cls;
        pieces = $urandom_range(1, 8);
        for (int p = 0; p < pieces; p++) begin
            pick = $urandom_range(0, 99);
            cls  = $urandom_range(cre_pkg::CLS_UPPER, cre_pkg::CLS_DIGIT);
            if (pick < 40) begin
                lo = class_byte(cls);
                hi = class_byte(cls);
                // mostly ascending spans, some descending ones left as is
                if (lo > hi && $urandom_range(0, 3) != 0) begin
                    swap = lo;
                    lo   = hi;
                    hi   = swap;
                end
                text_bytes.push_back(lo);
                text_bytes.push_back(cre_pkg::CHR_HYPHEN);
                text_bytes.push_back(hi);
            end else if (pick < 65) begin
                text_bytes.push_back(class_byte(cls));
            end else if (pick < 82) begin
                text_bytes.push_back(cre_pkg::CHR_HYPHEN);
            end else begin
                text_bytes.push_back(8'($urandom_range(0, 255)));
            end
        end
        foreach (text_bytes[i]) begin
            offer_item(text_bytes[i], i == text_bytes.size() - 1, 1'b0, NO_RESULT);
            if (text_bytes[i] == cre_pkg::CHR_HYPHEN
                    || byte_class(text_bytes[i]) != cre_pkg::CLS_NONE)
                counted++;
        end
    endtask

    // Drive the result channel: random idling plus long requested stalls
    always @(posedge aclk) begin
        if (stall_left == 0 && stall_served != stall_asked) begin
            stall_served = stall_served + 1;
            stall_left   = LONG_STALL;
        end
        if (stall_left != 0) begin
            stall_left = stall_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
        end
    end

    // Check each result beat against the oldest expected one
    always @(posedge aclk) begin
        cre_pkg::out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expanded_chars.size() == 0) begin
                report_mismatch("result beat with nothing expected", int'(m_data), 0);
            end else begin
                want = expanded_chars.pop_front();
                if (m_data.char_out !== want.char_out)
                    report_mismatch("char_out", int'(m_data.char_out), int'(want.char_out));
                if (m_data.has_char !== want.has_char)
                    report_mismatch("has_char", int'(m_data.has_char), int'(want.has_char));
                if (m_data.run_last !== want.run_last)
                    report_mismatch("run_last", int'(m_data.run_last), int'(want.run_last));
                if (m_data.text_end !== want.text_end)
                    report_mismatch("text_end", int'(m_data.text_end), int'(want.text_end));
            end
        end
    end

    // Stimulus
    initial begin
        int counted;
        int waited;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Walk the directed table
        foreach (directed_rows[r])
            offer_item(directed_rows[r].ch, directed_rows[r].fin,
                       directed_rows[r].use_want, directed_rows[r].want);

        // Hold the sender until every expected beat has come back
        s_valid <= 1'b0;
        while (expanded_chars.size() != 0) @(posedge aclk);

        // Random texts under three idling mixes
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    sender_idle_pct = 24;
                    receiver_idle_pct <= 63;
                end
                1: begin
                    sender_idle_pct = 63;
                    receiver_idle_pct <= 24;
                    stall_asked <= stall_asked + 1;
                end
                default: begin
                    sender_idle_pct = 0;
                    receiver_idle_pct <= 0;
                end
            endcase
            counted = 0;
            while (counted < PHASE_ITEMS) send_random_text(counted);
        end
        s_valid <= 1'b0;

        // Drain outstanding beats, then give the block time to go quiet
        waited = 0;
        while (expanded_chars.size() != 0 && waited < 20000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (expanded_chars.size() != 0)
            report_mismatch("result beats never produced", expanded_chars.size(), 0);

        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Stop a hung run
    initial begin
        #5000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
